>>> design/assert_macros.svh
// Assertion macros shared by the event-step queue simulator RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising clock edge outside reset.
`define MSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Require cons in the cycle after ante.
`define MSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/msq_pkg.sv
// Types, widths and codes for the event-step queue simulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package msq_pkg;

    localparam int TIME_W    = 40;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int DRAW_W    = 20;
    localparam int EV_W      = 2;
    localparam int QLEN_W    = 6;
    localparam int SRV_IDX_W = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  TARGET_RESET = 32'd1000;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [EV_W-1:0] EV_ARRIVAL = 2'd0;
    localparam logic [EV_W-1:0] EV_DEPART  = 2'd1;
    localparam logic [EV_W-1:0] EV_START   = 2'd2;

    typedef logic [TIME_W-1:0] time_t;

    // Earliest-event search and first-idle search, passed along the server cells
    typedef struct packed {
        time_t                time_v;
        logic                 is_srv;
        logic [SRV_IDX_W-1:0] idx;
        logic                 idle_found;
        logic [SRV_IDX_W-1:0] idle_idx;
    } srv_chain_t;

    typedef struct packed {
        logic                 clear;
        logic                 arrive;
        logic                 depart;
        logic                 queue_empty;
        logic [SRV_IDX_W-1:0] pick_idx;
        time_t                new_finish;
    } srv_ctrl_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        time_t stamp;
    } stk_ctrl_t;

    function automatic time_t time_add(input time_t a, input logic [DRAW_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W+1)'(b);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/msq_stamp_cell.sv
// One arrival-stamp cell of the waiting line; shifts towards the head on a pop.
// Depends on msq_pkg.
`default_nettype none

module msq_stamp_cell
    import msq_pkg::*;
(
    input  wire logic      aclk,
    input  wire stk_ctrl_t ctrl,
    input  wire logic      sel,
    input  wire time_t     stamp_up,
    output time_t          stamp
);

    time_t stamp_reg;
    time_t stamp_next;

    always_comb begin
        stamp_next = stamp_reg;
        if (ctrl.pop) begin
            stamp_next = stamp_up;
        end else if (ctrl.push && sel) begin
            stamp_next = ctrl.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg <= stamp_next;
    end

    assign stamp = stamp_reg;

endmodule

`default_nettype wire

>>> design/msq_server_cell.sv
// One server cell: busy flag and finish time, plus its stage of the
// earliest-event and first-idle search. Depends on msq_pkg.
`default_nettype none

module msq_server_cell
    import msq_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire srv_ctrl_t  ctrl,
    input  wire srv_chain_t chain_in,
    output srv_chain_t      chain_out,
    output logic            busy,
    output time_t           finish
);

    logic  busy_reg;
    logic  busy_next;
    time_t finish_reg;
    time_t finish_next;
    logic  arrive_me;
    logic  depart_me;

    assign arrive_me = ctrl.arrive && !chain_in.idle_found && !busy_reg;
    assign depart_me = ctrl.depart && (ctrl.pick_idx == SRV_IDX_W'(CELL_IDX));

    always_comb begin
        chain_out = chain_in;
        if (busy_reg && (finish_reg < chain_in.time_v)) begin
            chain_out.time_v = finish_reg;
            chain_out.is_srv = 1'b1;
            chain_out.idx    = SRV_IDX_W'(CELL_IDX);
        end
        if (!chain_in.idle_found && !busy_reg) begin
            chain_out.idle_found = 1'b1;
            chain_out.idle_idx   = SRV_IDX_W'(CELL_IDX);
        end
    end

    always_comb begin
        busy_next   = busy_reg;
        finish_next = finish_reg;
        if (ctrl.clear) begin
            busy_next   = 1'b0;
            finish_next = '0;
        end else if (arrive_me) begin
            busy_next   = 1'b1;
            finish_next = ctrl.new_finish;
        end else if (depart_me) begin
            if (ctrl.queue_empty) begin
                busy_next = 1'b0;
            end else begin
                finish_next = ctrl.new_finish;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            finish_reg <= '0;
        end else begin
            busy_reg   <= busy_next;
            finish_reg <= finish_next;
        end
    end

    assign busy   = busy_reg;
    assign finish = finish_reg;

endmodule

`default_nettype wire

>>> design/multi_server_queue_event_step.sv
// Multi-server FIFO queue simulator, one event per request, with result register.
// Depends on msq_pkg, msq_server_cell, msq_stamp_cell and assert_macros.svh.
//
// Each accepted request (start a run, or process the next event) yields exactly one
// result in the next cycle, and a new request is accepted in every cycle out of reset while
// the result register is empty or being taken, so the sustained rate is one request per
// cycle. The next event is found by a search that passes through the row of server cells;
// the waiting line is a row of stamp cells that shifts one place towards the head on every
// departure that starts a waiting request. No clearing pass is needed after reset.
// served_target is written through the cfg port, which is ready whenever out of reset.
`default_nettype none
`include "assert_macros.svh"

module multi_server_queue_event_step
    import msq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 36,
    parameter int SERVER_COUNT = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [DRAW_W-1:0] s_interarrival_draw,
    input  wire logic [DRAW_W-1:0] s_service_draw,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [EV_W-1:0]        m_event_res,
    output logic                   m_server,
    output logic [TIME_W-1:0]      m_sim_time,
    output logic [QLEN_W-1:0]      m_queue_length,
    output logic [QLEN_W-1:0]      m_in_system,
    output logic [TIME_W-1:0]      m_wait_delay,
    output logic [CNT_W-1:0]       m_requests_served,
    output logic [CNT_W-1:0]       m_requests_arrived,
    output logic [CNT_W-1:0]       m_requests_dropped,
    output logic [SUM_W-1:0]       m_total_wait,
    output logic [SUM_W-1:0]       m_total_sojourn,
    output logic                   m_done_res
);

    localparam int QW     = $clog2(QUEUE_DEPTH + 1);
    localparam int BW     = $clog2(SERVER_COUNT + 1);
    localparam int SYS_W  = $clog2(QUEUE_DEPTH + SERVER_COUNT + 1);
    localparam int WIDE_W = (SYS_W > QLEN_W) ? SYS_W : QLEN_W;

    logic [CNT_W-1:0]  target_reg;
    time_t             clock_reg, clock_next;
    time_t             next_arr_reg, next_arr_next;
    logic [QW-1:0]     waiting_reg, waiting_next;
    logic [CNT_W-1:0]  served_reg, served_next;
    logic [CNT_W-1:0]  arrived_reg, arrived_next;
    logic [CNT_W-1:0]  dropped_reg, dropped_next;
    logic [SUM_W-1:0]  wait_sum_reg, wait_sum_next;
    logic [SUM_W-1:0]  sojourn_reg, sojourn_next;
    logic              m_valid_reg;

    logic [EV_W-1:0]   ev_reg;
    logic              server_reg;
    time_t             sim_time_reg;
    logic [QLEN_W-1:0] qlen_reg;
    logic [QLEN_W-1:0] in_sys_reg;
    time_t             delay_reg;
    logic              done_reg;

    logic              take;
    logic              is_start;
    srv_chain_t        chain [0:SERVER_COUNT];
    srv_chain_t        best;
    srv_ctrl_t         sctl;
    stk_ctrl_t         qctl;
    logic [SERVER_COUNT-1:0] busy_vec;
    time_t             srv_finish [0:SERVER_COUNT-1];
    time_t             stamp_q [0:QUEUE_DEPTH-1];
    logic [BW-1:0]     busy_cnt, busy_cnt_next;

    time_t             clk_step;
    time_t             new_finish;
    time_t             svc_len;
    time_t             delay;
    logic              q_full;
    logic              q_empty;
    logic [EV_W-1:0]   ev_next;
    logic [SRV_IDX_W-1:0] srv_next;
    time_t             delay_next;
    logic [WIDE_W-1:0] q_wide;
    logic [WIDE_W-1:0] sys_wide;
    logic [TIME_W:0]   dep_sum;

    assign take      = s_valid && s_ready;
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign cfg_ready = aresetn;
    assign is_start  = (s_kind == KIND_START);

    assign chain[0] = '{time_v: next_arr_reg, is_srv: 1'b0, idx: '0,
                        idle_found: 1'b0, idle_idx: '0};
    assign best     = chain[SERVER_COUNT];

    assign clk_step   = best.time_v;
    assign new_finish = time_add(clk_step, s_service_draw);
    assign svc_len    = new_finish - clk_step;
    assign delay      = (clk_step >= stamp_q[0]) ? clk_step - stamp_q[0] : '0;
    assign dep_sum    = {1'b0, delay} + {1'b0, svc_len};
    assign q_full     = (waiting_reg == QW'(QUEUE_DEPTH));
    assign q_empty    = (waiting_reg == '0);

    assign sctl.clear       = take && is_start;
    assign sctl.arrive      = take && !is_start && !best.is_srv;
    assign sctl.depart      = take && !is_start && best.is_srv;
    assign sctl.queue_empty = q_empty;
    assign sctl.pick_idx    = best.idx;
    assign sctl.new_finish  = new_finish;

    assign qctl.push  = sctl.arrive && !best.idle_found && !q_full;
    assign qctl.pop   = sctl.depart && !q_empty;
    assign qctl.stamp = clk_step;

    for (genvar g = 0; g < SERVER_COUNT; g++) begin : g_srv
        msq_server_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (sctl),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .busy      (busy_vec[g]),
            .finish    (srv_finish[g])
        );
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_stamp
        time_t up;
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign up = '0;
        end else begin : g_body
            assign up = stamp_q[g+1];
        end
        msq_stamp_cell u_cell (
            .aclk     (aclk),
            .ctrl     (qctl),
            .sel      (waiting_reg == QW'(g)),
            .stamp_up (up),
            .stamp    (stamp_q[g])
        );
    end

    always_comb begin
        busy_cnt = '0;
        for (int k = 0; k < SERVER_COUNT; k++) begin
            busy_cnt = busy_cnt + BW'(busy_vec[k]);
        end
    end

    always_comb begin
        clock_next    = clock_reg;
        next_arr_next = next_arr_reg;
        waiting_next  = waiting_reg;
        served_next   = served_reg;
        arrived_next  = arrived_reg;
        dropped_next  = dropped_reg;
        wait_sum_next = wait_sum_reg;
        sojourn_next  = sojourn_reg;
        busy_cnt_next = busy_cnt;
        ev_next       = EV_START;
        srv_next      = '0;
        delay_next    = '0;
        if (is_start) begin
            clock_next    = '0;
            next_arr_next = TIME_W'(s_interarrival_draw);
            waiting_next  = '0;
            served_next   = '0;
            arrived_next  = '0;
            dropped_next  = '0;
            wait_sum_next = '0;
            sojourn_next  = '0;
            busy_cnt_next = '0;
        end else if (!best.is_srv) begin
            ev_next       = EV_ARRIVAL;
            clock_next    = clk_step;
            next_arr_next = time_add(clk_step, s_interarrival_draw);
            arrived_next  = arrived_reg + 1'b1;
            if (best.idle_found) begin
                served_next   = served_reg + 1'b1;
                sojourn_next  = sum_add(sojourn_reg, SUM_W'(svc_len));
                srv_next      = best.idle_idx;
                busy_cnt_next = busy_cnt + 1'b1;
            end else if (!q_full) begin
                waiting_next = waiting_reg + 1'b1;
            end else begin
                dropped_next = dropped_reg + 1'b1;
            end
        end else begin
            ev_next    = EV_DEPART;
            clock_next = clk_step;
            srv_next   = best.idx;
            if (q_empty) begin
                busy_cnt_next = busy_cnt - 1'b1;
            end else begin
                delay_next    = delay;
                waiting_next  = waiting_reg - 1'b1;
                wait_sum_next = sum_add(wait_sum_reg, SUM_W'(delay));
                sojourn_next  = sum_add(sojourn_reg, SUM_W'(dep_sum));
                served_next   = served_reg + 1'b1;
            end
        end
    end

    assign q_wide   = WIDE_W'(waiting_next);
    assign sys_wide = WIDE_W'(waiting_next) + WIDE_W'(busy_cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_RESET;
            clock_reg    <= '0;
            next_arr_reg <= '0;
            waiting_reg  <= '0;
            served_reg   <= '0;
            arrived_reg  <= '0;
            dropped_reg  <= '0;
            wait_sum_reg <= '0;
            sojourn_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                target_reg <= cfg_data;
            end
            if (take) begin
                clock_reg    <= clock_next;
                next_arr_reg <= next_arr_next;
                waiting_reg  <= waiting_next;
                served_reg   <= served_next;
                arrived_reg  <= arrived_next;
                dropped_reg  <= dropped_next;
                wait_sum_reg <= wait_sum_next;
                sojourn_reg  <= sojourn_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ev_reg       <= ev_next;
            server_reg   <= srv_next[0];
            sim_time_reg <= clock_next;
            qlen_reg     <= q_wide[QLEN_W-1:0];
            in_sys_reg   <= sys_wide[QLEN_W-1:0];
            delay_reg    <= delay_next;
            done_reg     <= (served_next >= target_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_res        = ev_reg;
    assign m_server           = server_reg;
    assign m_sim_time         = sim_time_reg;
    assign m_queue_length     = qlen_reg;
    assign m_in_system        = in_sys_reg;
    assign m_wait_delay       = delay_reg;
    assign m_requests_served  = served_reg;
    assign m_requests_arrived = arrived_reg;
    assign m_requests_dropped = dropped_reg;
    assign m_total_wait       = wait_sum_reg;
    assign m_total_sojourn    = sojourn_reg;
    assign m_done_res         = done_reg;

    `MSQ_ASSERT(a_queue_bound, aclk, aresetn, waiting_reg <= QW'(QUEUE_DEPTH),
                "queue overfilled")
    `MSQ_ASSERT(a_queue_needs_busy, aclk, aresetn, (waiting_reg == '0) || (&busy_vec),
                "request waits while a server idles")
    `MSQ_ASSERT(a_finish_ahead, aclk, aresetn,
                !busy_vec[0] || (srv_finish[0] >= clock_reg),
                "busy server finishes in the past")
    `MSQ_ASSERT_NEXT(a_start_result, aclk, aresetn, take && is_start,
                     m_valid && (m_event_res == EV_START) && (m_sim_time == '0)
                     && (m_requests_served == '0),
                     "start request gave wrong result")

endmodule

`default_nettype wire

>>> bench/tb_multi_server_queue_event_step.sv
// Testbench for the event-step two-server queue simulator: directed and random
// requests over valid/ready with random idling, checked against a behavioural model.
// Depends on msq_pkg and the multi_server_queue_event_step RTL.

module tb_multi_server_queue_event_step
    import msq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = 36;
    localparam int SERVERS     = 2;
    localparam int HOLD_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [EV_W-1:0]   ev;
        logic              srv;
        time_t             sim_time;
        logic [QLEN_W-1:0] qlen;
        logic [QLEN_W-1:0] in_sys;
        time_t             wait_delay;
        logic [CNT_W-1:0]  served;
        logic [CNT_W-1:0]  arrived;
        logic [CNT_W-1:0]  dropped;
        logic [SUM_W-1:0]  wait_total;
        logic [SUM_W-1:0]  soj_total;
        logic              done;
    } event_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_kind;
    logic [DRAW_W-1:0] s_interarrival_draw;
    logic [DRAW_W-1:0] s_service_draw;
    logic              m_valid;
    logic              m_ready;
    logic [EV_W-1:0]   m_event_res;
    logic              m_server;
    logic [TIME_W-1:0] m_sim_time;
    logic [QLEN_W-1:0] m_queue_length;
    logic [QLEN_W-1:0] m_in_system;
    logic [TIME_W-1:0] m_wait_delay;
    logic [CNT_W-1:0]  m_requests_served;
    logic [CNT_W-1:0]  m_requests_arrived;
    logic [CNT_W-1:0]  m_requests_dropped;
    logic [SUM_W-1:0]  m_total_wait;
    logic [SUM_W-1:0]  m_total_sojourn;
    logic              m_done_res;

    // model state
    logic [CNT_W-1:0] target_model;
    time_t            run_clock;
    time_t            next_arrival_at;
    logic             srv_busy [SERVERS];
    time_t            srv_finish [SERVERS];
    time_t            waiting_stamps [$];
    logic [CNT_W-1:0] served_n;
    logic [CNT_W-1:0] arrived_n;
    logic [CNT_W-1:0] dropped_n;
    logic [SUM_W-1:0] wait_total;
    logic [SUM_W-1:0] sojourn_total;

    event_result_t pending_results [$];
    int            fail_count;
    int            cycle_count;
    bit            idle_en;
    bit            long_hold_req;

    multi_server_queue_event_step #(
        .QUEUE_DEPTH (LINE_DEPTH),
        .SERVER_COUNT(SERVERS)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_interarrival_draw(s_interarrival_draw),
        .s_service_draw     (s_service_draw),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_server           (m_server),
        .m_sim_time         (m_sim_time),
        .m_queue_length     (m_queue_length),
        .m_in_system        (m_in_system),
        .m_wait_delay       (m_wait_delay),
        .m_requests_served  (m_requests_served),
        .m_requests_arrived (m_requests_arrived),
        .m_requests_dropped (m_requests_dropped),
        .m_total_wait       (m_total_wait),
        .m_total_sojourn    (m_total_sojourn),
        .m_done_res         (m_done_res)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic time_t sat_time(input time_t a, input logic [DRAW_W-1:0] b);
        if (TIME_MAX - a < time_t'(b))
            return TIME_MAX;
        return a + time_t'(b);
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        if (SUM_MAX - a < b)
            return SUM_MAX;
        return a + b;
    endfunction

    function automatic void restart_run();
        run_clock       = '0;
        next_arrival_at = '0;
        for (int i = 0; i < SERVERS; i++) begin
            srv_busy[i]   = 1'b0;
            srv_finish[i] = '0;
        end
        waiting_stamps.delete();
        served_n      = '0;
        arrived_n     = '0;
        dropped_n     = '0;
        wait_total    = '0;
        sojourn_total = '0;
    endfunction

    function automatic event_result_t queue_event_outcome(input logic kind,
                                                          input logic [DRAW_W-1:0] ia,
                                                          input logic [DRAW_W-1:0] sv);
        event_result_t r;
        int            pick;
        int            free_srv;
        int            busy_n;
        time_t         best;
        time_t         head;
        time_t         delay;
        r     = '{default: '0};
        delay = '0;
        if (kind == KIND_START) begin
            restart_run();
            next_arrival_at = time_t'(ia);
            r.ev = EV_START;
        end else begin
            pick = -1;
            best = next_arrival_at;
            for (int i = 0; i < SERVERS; i++) begin
                if (srv_busy[i] && srv_finish[i] < best) begin
                    best = srv_finish[i];
                    pick = i;
                end
            end
            run_clock = best;
            if (pick < 0) begin
                r.ev            = EV_ARRIVAL;
                next_arrival_at = sat_time(run_clock, ia);
                arrived_n       = arrived_n + 1'b1;
                free_srv        = -1;
                for (int i = 0; i < SERVERS; i++)
                    if (!srv_busy[i] && free_srv < 0)
                        free_srv = i;
                if (free_srv >= 0) begin
                    srv_busy[free_srv]   = 1'b1;
                    srv_finish[free_srv] = sat_time(run_clock, sv);
                    served_n             = served_n + 1'b1;
                    sojourn_total        = sat_sum(sojourn_total,
                                                   SUM_W'(srv_finish[free_srv] - run_clock));
                    r.srv = free_srv[0];
                end else if (waiting_stamps.size() < LINE_DEPTH) begin
                    waiting_stamps.push_back(run_clock);
                end else begin
                    dropped_n = dropped_n + 1'b1;
                end
            end else begin
                r.ev  = EV_DEPART;
                r.srv = pick[0];
                if (waiting_stamps.size() == 0) begin
                    srv_busy[pick] = 1'b0;
                end else begin
                    head             = waiting_stamps.pop_front();
                    delay            = (run_clock >= head) ? run_clock - head : '0;
                    srv_finish[pick] = sat_time(run_clock, sv);
                    wait_total       = sat_sum(wait_total, SUM_W'(delay));
                    sojourn_total    = sat_sum(sojourn_total, SUM_W'(delay)
                                               + SUM_W'(srv_finish[pick] - run_clock));
                    served_n         = served_n + 1'b1;
                end
            end
        end
        busy_n = 0;
        for (int i = 0; i < SERVERS; i++)
            busy_n += srv_busy[i] ? 1 : 0;
        r.sim_time   = run_clock;
        r.qlen       = QLEN_W'(waiting_stamps.size());
        r.in_sys     = QLEN_W'(waiting_stamps.size() + busy_n);
        r.wait_delay = delay;
        r.served     = served_n;
        r.arrived    = arrived_n;
        r.dropped    = dropped_n;
        r.wait_total = wait_total;
        r.soj_total  = sojourn_total;
        r.done       = (served_n >= target_model);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        event_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("event_res", e.ev, m_event_res);
                check_field("server", e.srv, m_server);
                check_field("sim_time", e.sim_time, m_sim_time);
                check_field("queue_length", e.qlen, m_queue_length);
                check_field("in_system", e.in_sys, m_in_system);
                check_field("wait_delay", e.wait_delay, m_wait_delay);
                check_field("requests_served", e.served, m_requests_served);
                check_field("requests_arrived", e.arrived, m_requests_arrived);
                check_field("requests_dropped", e.dropped, m_requests_dropped);
                check_field("total_wait", e.wait_total, m_total_wait);
                check_field("total_sojourn", e.soj_total, m_total_sojourn);
                check_field("done_res", e.done, m_done_res);
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                stall = idle_en ? $urandom_range(0, 6) : 0;
                if (stall > 0) begin
                    m_ready = 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // entered and left at a falling edge
    task automatic send_request(input logic kind, input logic [DRAW_W-1:0] ia,
                                input logic [DRAW_W-1:0] sv);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_kind              = kind;
        s_interarrival_draw = ia;
        s_service_draw      = sv;
        s_valid             = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(queue_event_outcome(kind, ia, sv));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_served_target(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        target_model = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [DRAW_W-1:0] pick_draw(input int unsigned lim);
        if ($urandom_range(0, 7) == 0)
            return DRAW_W'($urandom_range(0, 20'hFFFFF));
        return DRAW_W'($urandom_range(0, lim));
    endfunction

    function automatic int unsigned pick_scale();
        case ($urandom_range(0, 3))
            0: return 15;
            1: return 255;
            2: return 4095;
            default: return 20'hFFFFF;
        endcase
    endfunction

    task automatic test_step_from_reset();
        send_request(KIND_STEP, 20'd5, 20'd3);
        send_request(KIND_STEP, 20'd9, 20'd2);
    endtask

    task automatic test_directed_events();
        // zero draws: arrival wins ties, lower server wins among servers
        send_request(KIND_START, 20'd0, 20'hFFFFF);
        send_request(KIND_STEP, 20'd0, 20'd0);
        send_request(KIND_STEP, 20'd0, 20'd0);
        send_request(KIND_STEP, 20'd10, 20'hFFFFF);
        send_request(KIND_STEP, 20'hFFFFF, 20'hFFFFF);
        send_request(KIND_STEP, 20'hFFFFF, 20'd0);
        send_request(KIND_STEP, 20'hFFFFF, 20'd0);
        send_request(KIND_STEP, 20'd0, 20'd0);
        // queued requests picked up by departures with non-zero wait
        send_request(KIND_START, 20'd1, 20'd0);
        send_request(KIND_STEP, 20'd1, 20'd100);
        send_request(KIND_STEP, 20'd1, 20'd100);
        send_request(KIND_STEP, 20'd1, 20'd50);
        send_request(KIND_STEP, 20'd200, 20'd50);
        send_request(KIND_STEP, 20'd0, 20'd7);
        send_request(KIND_STEP, 20'd0, 20'hFFFFF);
        send_request(KIND_STEP, 20'd0, 20'd0);
        send_request(KIND_STEP, 20'hFFFFF, 20'd1);
    endtask

    task automatic test_queue_overflow();
        send_request(KIND_START, 20'd1, 20'd0);
        repeat (70)
            send_request(KIND_STEP, DRAW_W'($urandom_range(0, 3)),
                         DRAW_W'($urandom_range(20'hF0000, 20'hFFFFF)));
        repeat (50)
            send_request(KIND_STEP, 20'hFFFFF, DRAW_W'($urandom_range(0, 255)));
    endtask

    task automatic test_output_backpressure();
        idle_en = 1'b0;
        send_request(KIND_START, DRAW_W'($urandom_range(0, 15)), 20'd0);
        long_hold_req = 1'b1;
        repeat (24)
            send_request(KIND_STEP, DRAW_W'($urandom_range(0, 15)),
                         DRAW_W'($urandom_range(0, 63)));
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items);
        int unsigned ia_lim;
        int unsigned sv_lim;
        for (int i = 0; i < n_items; i++) begin
            if (i == 0 || $urandom_range(0, 49) == 0) begin
                ia_lim = pick_scale();
                sv_lim = pick_scale();
                send_request(KIND_START, pick_draw(ia_lim), pick_draw(sv_lim));
            end else begin
                send_request(KIND_STEP, pick_draw(ia_lim), pick_draw(sv_lim));
            end
        end
    endtask

    initial begin
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_data            = '0;
        s_valid             = 1'b0;
        s_kind              = KIND_START;
        s_interarrival_draw = '0;
        s_service_draw      = '0;
        fail_count          = 0;
        cycle_count         = 0;
        idle_en             = 1'b1;
        long_hold_req       = 1'b0;
        target_model        = TARGET_RESET;
        restart_run();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_step_from_reset();
        test_directed_events();
        set_served_target(32'd1);
        test_queue_overflow();
        set_served_target(32'hFFFF_FFFF);
        test_output_backpressure();
        set_served_target(CNT_W'($urandom_range(2, 400)));
        test_random_traffic(135);
        set_served_target(32'd1);
        idle_en = 1'b0;
        test_random_traffic(135);
        idle_en = 1'b1;
        set_served_target(32'hFFFF_FFFF);
        test_random_traffic(135);
        set_served_target(CNT_W'($urandom_range(20, 120)));
        test_random_traffic(135);

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/msq_pkg.sv
design/msq_stamp_cell.sv
design/msq_server_cell.sv
design/multi_server_queue_event_step.sv
bench/tb_multi_server_queue_event_step.sv
